// ===== rtl/etcf_pkg.sv =====
// shared types, constants and decode helpers for the edge timestamp capture fifo
package etcf_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int TIME_W = 32;
  localparam int CNT_W = 32;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // edge mode register codes, any other code counts falling edges
  localparam logic [1:0] EDGE_RISING = 2'd0;
  localparam logic [1:0] EDGE_FALLING = 2'd1;
  localparam logic [1:0] EDGE_BOTH = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic REG_EDGE_MODE = 1'b0;
  localparam logic REG_CAPTURE_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_POP = 2'd1,
    CMD_RESYNC = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic pin_level;
    logic [TIME_W-1:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic pop_valid;
    logic [TIME_W-1:0] pulse_time_us;
    logic popped_passive;
    logic captured;
    logic [CNT_W-1:0] overflow_total;
    logic [CNT_W-1:0] pulse_total;
  } out_word_t;

  typedef struct packed {
    cmd_t kind;
    logic pin_level;
    logic [TIME_W-1:0] time_us;
  } queue_entry_t;

  typedef struct packed {
    logic [1:0] edge_mode;
    logic capture_enable;
  } cfg_t;

  // map the raw command field to its kind
  function automatic cmd_t classify(input logic [1:0] command);
    cmd_t kind;
    unique case (command)
      2'd0: kind = CMD_SAMPLE;
      2'd1: kind = CMD_POP;
      2'd2: kind = CMD_RESYNC;
      default: kind = CMD_NONE;
    endcase
    return kind;
  endfunction

endpackage

// ===== rtl/etcf_front.sv =====
// front end: accepts command words, classifies them and queues them for the back end
module etcf_front
  import etcf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  in_word_t     cmd_word,
  output logic         q_valid,
  output queue_entry_t q_entry,
  input  logic         q_take
);

  queue_entry_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  // handshake and queue status
  assign cmd_ready = (count != 2'd2);
  assign push = cmd_valid && cmd_ready;
  assign pop = q_take && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_entry = slots[rd_ptr];

  // queue payload, classified on entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].kind <= classify(cmd_word.command);
      slots[wr_ptr].pin_level <= cmd_word.pin_level;
      slots[wr_ptr].time_us <= cmd_word.time_us;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/etcf_back.sv =====
// back end: edge detection, capture ring, counters and the result register
module etcf_back
  import etcf_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  queue_entry_t q_entry,
  output logic         q_take,
  output logic         res_valid,
  input  logic         res_ready,
  output out_word_t    res_word
);

  localparam int IDX_W = $clog2(RING_DEPTH);

  back_state_t state;
  back_state_t state_next;

  logic             last_level;
  logic             last_level_next;
  logic             saw_passive;
  logic             saw_passive_next;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] wr_idx_next;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_idx_next;
  logic [CNT_W-1:0] overflow_count;
  logic [CNT_W-1:0] overflow_count_next;
  logic [CNT_W-1:0] pulse_count;
  logic [CNT_W-1:0] pulse_count_next;

  logic [TIME_W:0]  ring_mem [RING_DEPTH];
  logic [TIME_W:0]  rd_data;
  logic             mem_we;
  logic             mem_re;
  logic             stored_passive;

  logic             start;
  logic             ring_empty;
  logic             ring_full;
  logic             level_change;
  logic             rising;
  logic             falling;
  logic             mode_hit;
  logic             edge_hit;
  logic             push;
  logic             res_load;
  out_word_t        res_next;

  // ring status and edge classification
  assign ring_empty = (wr_idx == rd_idx);
  assign ring_full = (IDX_W'(wr_idx + 1'b1) == rd_idx);
  assign level_change = cfg.capture_enable && (q_entry.pin_level != last_level);
  assign rising = q_entry.pin_level & ~last_level;
  assign falling = ~q_entry.pin_level & last_level;
  assign stored_passive = q_entry.pin_level | saw_passive;

  always_comb begin
    unique case (cfg.edge_mode)
      EDGE_RISING: mode_hit = rising;
      EDGE_BOTH:   mode_hit = 1'b1;
      default:     mode_hit = falling;
    endcase
  end

  assign edge_hit = level_change && mode_hit;
  assign push = edge_hit && !ring_full;

  // a word starts only when the result register is free this cycle
  assign start = q_valid && (state == BK_IDLE) && (!res_valid || res_ready);
  assign q_take = start;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (start && (q_entry.kind == CMD_POP) && !ring_empty) begin
          state_next = BK_POP;
        end
      end
      BK_POP: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // command execution and result formation
  always_comb begin
    last_level_next = last_level;
    saw_passive_next = saw_passive;
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    overflow_count_next = overflow_count;
    pulse_count_next = pulse_count;
    mem_we = 1'b0;
    mem_re = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    unique case (state)
      BK_IDLE: begin
        if (start) begin
          unique case (q_entry.kind)
            CMD_SAMPLE: begin
              if (q_entry.pin_level) begin
                saw_passive_next = 1'b1;
              end
              if (level_change) begin
                last_level_next = q_entry.pin_level;
              end
              if (edge_hit) begin
                pulse_count_next = pulse_count + 1'b1;
                if (push) begin
                  mem_we = 1'b1;
                  saw_passive_next = 1'b0;
                  wr_idx_next = IDX_W'(wr_idx + 1'b1);
                end else begin
                  overflow_count_next = overflow_count + 1'b1;
                end
              end
              res_load = 1'b1;
              res_next.captured = push;
            end
            CMD_POP: begin
              if (!ring_empty) begin
                mem_re = 1'b1;
                rd_idx_next = IDX_W'(rd_idx + 1'b1);
              end else begin
                res_load = 1'b1;
              end
            end
            CMD_RESYNC: begin
              last_level_next = q_entry.pin_level;
              saw_passive_next = q_entry.pin_level;
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      BK_POP: begin
        res_load = 1'b1;
        res_next.pop_valid = 1'b1;
        res_next.pulse_time_us = rd_data[TIME_W-1:0];
        res_next.popped_passive = rd_data[TIME_W];
      end
    endcase
    res_next.overflow_total = overflow_count_next;
    res_next.pulse_total = pulse_count_next;
  end

  // capture ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_idx] <= {stored_passive, q_entry.time_us};
    end
    if (mem_re) begin
      rd_data <= ring_mem[rd_idx];
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      last_level <= 1'b1;
      saw_passive <= 1'b1;
      wr_idx <= '0;
      rd_idx <= '0;
      overflow_count <= '0;
      pulse_count <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      last_level <= last_level_next;
      saw_passive <= saw_passive_next;
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      overflow_count <= overflow_count_next;
      pulse_count <= pulse_count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_word <= res_next;
    end
  end

`ifndef SYNTHESIS
  // the pop read state delivers the popped entry in the following cycle
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == BK_POP) |=> (res_valid && res_word.pop_valid))
    else $error("pop read did not produce a valid result");

  // the pulse counter moves only on sample words
  a_pulse_only_sample: assert property (@(posedge clk) disable iff (rst)
    !(start && (q_entry.kind == CMD_SAMPLE)) |=> $stable(pulse_count))
    else $error("pulse count changed without a sample");

  // every dropped edge is also a counted edge
  a_overflow_counts_pulse: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (overflow_count != $past(overflow_count)))
      |-> (pulse_count != $past(pulse_count)))
    else $error("overflow counted without a pulse");
`endif

endmodule

// ===== rtl/edge_timestamp_capture_fifo_top.sv =====
// top level: register port, front queue and back end of the edge timestamp capture fifo
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_word) takes one word per command:
//   sample a pin level with its microsecond time, pop the oldest capture,
//   or resync the last level and passive mark from the pin.
//   res channel (res_valid/res_ready/res_word) returns exactly one word per
//   command, in order, with the popped capture, the captured flag and the
//   running overflow and pulse totals.
//   Registers over the APB port: edge_mode at 0x0, capture_enable at 0x4; the user
//   must write them only while no command is in flight, the block leaves it unchecked.
// Timing: sample, resync and empty pops pass the queue slot and the result
//   register; a pop that returns an entry also passes the registered ring read.
// Throughput: one word per cycle while res_ready is high, except a pop that returns
//   an entry, which holds the back end in BK_POP for the ring's single read port.
// Reset: rst is synchronous; it empties the command queue and the ring, clears
//   both totals, and sets edge_mode to falling, capture on, last level high.
// Stalls: a 2-word queue parts the two sides; when res_ready is low the result
//   register holds, the back end stops and cmd_ready drops once the queue fills.
module edge_timestamp_capture_fifo_top
  import etcf_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  in_word_t          cmd_word,
  output logic              res_valid,
  input  logic              res_ready,
  output out_word_t         res_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t         cfg;
  logic         reg_wr;
  logic         reg_sel;
  logic         q_valid;
  logic         q_take;
  queue_entry_t q_entry;

  // register decode
  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_mode <= EDGE_FALLING;
      cfg.capture_enable <= 1'b1;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_EDGE_MODE:      cfg.edge_mode <= pwdata[1:0];
        REG_CAPTURE_ENABLE: cfg.capture_enable <= pwdata[0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_EDGE_MODE:      prdata = {{(DATA_W-2){1'b0}}, cfg.edge_mode};
      REG_CAPTURE_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg.capture_enable};
    endcase
  end

  etcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_word  (cmd_word),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take)
  );

  etcf_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_take    (q_take),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule

// ===== test/tb_edge_timestamp_capture_fifo_top.sv =====
// self-checking testbench for the edge timestamp capture fifo top level
module tb_edge_timestamp_capture_fifo_top
  import etcf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // edge mode code outside the documented range, decoded as falling
  localparam logic [1:0] EDGE_ALIAS = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS = 8;
  localparam int SEG_WORDS = 100;
  localparam int SETTLE = 8;

  // tracks pin level, passive mark, capture ring and totals, holds the words due out
  class capture_ring_tracker;
    logic [1:0] edge_mode = EDGE_FALLING;
    logic capture_enable = 1'b1;
    logic last_level = 1'b1;
    logic saw_passive = 1'b1;
    int wr_idx = 0;
    int rd_idx = 0;
    logic [TIME_W-1:0] time_store [RING_DEPTH_DEF];
    logic passive_store [RING_DEPTH_DEF];
    logic [CNT_W-1:0] overflow_count = '0;
    logic [CNT_W-1:0] pulse_count = '0;
    out_word_t pending_results [$];
    int mismatch_count = 0;

    function void set_register(input logic reg_sel, input logic [1:0] value);
      if (reg_sel == REG_EDGE_MODE) edge_mode = value;
      else capture_enable = value[0];
    endfunction

    // work out the result word of one accepted command word
    function void note_command(input in_word_t w);
      out_word_t r;
      logic rising;
      logic falling;
      logic hit;
      int nxt;
      r = '0;
      if (w.command == CMD_SAMPLE) begin
        if (w.pin_level) saw_passive = 1'b1;
        if (capture_enable && (w.pin_level != last_level)) begin
          rising = w.pin_level & ~last_level;
          falling = ~w.pin_level & last_level;
          last_level = w.pin_level;
          case (edge_mode)
            EDGE_BOTH: hit = 1'b1;
            EDGE_RISING: hit = rising;
            default: hit = falling;
          endcase
          if (hit) begin
            // ring keeps one slot free to tell full from empty
            nxt = (wr_idx + 1) % RING_DEPTH_DEF;
            if (nxt != rd_idx) begin
              time_store[wr_idx] = w.time_us;
              passive_store[wr_idx] = saw_passive;
              saw_passive = 1'b0;
              wr_idx = nxt;
              r.captured = 1'b1;
            end else begin
              overflow_count = overflow_count + 1'b1;
            end
            pulse_count = pulse_count + 1'b1;
          end
        end
      end else if (w.command == CMD_POP) begin
        if (rd_idx != wr_idx) begin
          r.pop_valid = 1'b1;
          r.pulse_time_us = time_store[rd_idx];
          r.popped_passive = passive_store[rd_idx];
          rd_idx = (rd_idx + 1) % RING_DEPTH_DEF;
        end
      end else if (w.command == CMD_RESYNC) begin
        last_level = w.pin_level;
        saw_passive = w.pin_level;
      end
      r.overflow_total = overflow_count;
      r.pulse_total = pulse_count;
      pending_results.push_back(r);
    endfunction

    function void report(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch %0d at %0t: %s", mismatch_count, $time, what);
    endfunction

    function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) report($sformatf("%s expected %h actual %h", name, want, got));
    endfunction

    // compare a result word against the oldest one due
    function void check_result(input out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      want = pending_results.pop_front();
      check_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
      check_field("pulse_time_us", want.pulse_time_us, got.pulse_time_us);
      check_field("popped_passive", 32'(want.popped_passive), 32'(got.popped_passive));
      check_field("captured", 32'(want.captured), 32'(got.captured));
      check_field("overflow_total", want.overflow_total, got.overflow_total);
      check_field("pulse_total", want.pulse_total, got.pulse_total);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  in_word_t cmd_word = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_word_t res_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int send_idle = 0;
  int recv_idle = 0;
  int cycle_count = 0;
  logic pin_now = 1'b1;
  logic [TIME_W-1:0] time_now = '0;
  capture_ring_tracker ring_model;

  edge_timestamp_capture_fifo_top uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_word(cmd_word),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_word(res_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random back pressure and result checking
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
    if (!rst && res_valid && res_ready) ring_model.check_result(res_word);
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // apb write: setup cycle, then access cycle
  task automatic reg_write(input logic reg_sel, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ring_model.set_register(reg_sel, value[1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // present one command word, with a random gap first, and hold it until taken
  task automatic send_command(input logic [1:0] command, input logic pin,
                              input logic [TIME_W-1:0] stamp);
    in_word_t w;
    w.command = command;
    w.pin_level = pin;
    w.time_us = stamp;
    if ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    ring_model.note_command(w);
  endtask

  // mostly edges on a moving time base, plus pops, resyncs and the unused command
  task automatic send_random(input int pop_pct);
    int r;
    logic [1:0] command;
    logic pin;
    r = $urandom_range(99);
    pin = 1'($urandom_range(1));
    if (r < pop_pct) begin
      command = CMD_POP;
    end else if (r < pop_pct + 5) begin
      command = CMD_RESYNC;
    end else if (r < pop_pct + 8) begin
      command = CMD_NONE;
    end else begin
      command = CMD_SAMPLE;
      if ($urandom_range(3) != 0) pin = ~pin_now;
    end
    if (command == CMD_SAMPLE || command == CMD_RESYNC) pin_now = pin;
    if ($urandom_range(9) == 0) time_now = $urandom();
    else time_now = time_now + $urandom_range(1, 5000);
    send_command(command, pin, time_now);
  endtask

  // wait for every result due, then let the pipeline settle
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (ring_model.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int pop_pct;
    ring_model = new();
    time_now = $urandom();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: falling edges, stamps at both ends, resync, unused command, pops
    reg_write(REG_EDGE_MODE, DATA_W'(EDGE_FALLING));
    reg_write(REG_CAPTURE_ENABLE, 1);
    send_command(CMD_SAMPLE, 1'b1, 32'h0000_0000);
    send_command(CMD_SAMPLE, 1'b0, 32'h0000_0000);
    send_command(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, 1'b0, 32'h1234_5678);
    send_command(CMD_RESYNC, 1'b1, 32'h0000_0000);
    send_command(CMD_RESYNC, 1'b0, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, 1'b1, 32'h8000_0001);
    send_command(CMD_NONE, 1'b1, 32'hFFFF_FFFF);
    send_command(CMD_POP, 1'b0, 32'h0000_0000);
    send_command(CMD_POP, 1'b1, 32'hFFFF_FFFF);
    send_command(CMD_POP, 1'b0, 32'h0000_0000);
    send_command(CMD_POP, 1'b1, 32'h0000_0000);
    drain_results();
    reg_write(REG_EDGE_MODE, DATA_W'(EDGE_RISING));
    send_command(CMD_SAMPLE, 1'b0, 32'h0000_0010);
    send_command(CMD_SAMPLE, 1'b1, 32'hA5A5_A5A5);
    drain_results();
    reg_write(REG_EDGE_MODE, DATA_W'(EDGE_BOTH));
    send_command(CMD_SAMPLE, 1'b0, 32'h5A5A_5A5A);
    send_command(CMD_SAMPLE, 1'b1, 32'h7FFF_FFFF);
    drain_results();
    reg_write(REG_EDGE_MODE, DATA_W'(EDGE_ALIAS));
    send_command(CMD_SAMPLE, 1'b0, 32'h0000_0100);
    send_command(CMD_SAMPLE, 1'b1, 32'h0000_0200);
    drain_results();
    // capture suspended: passive mark still follows a high level
    reg_write(REG_CAPTURE_ENABLE, 0);
    send_command(CMD_SAMPLE, 1'b0, 32'h0000_0300);
    send_command(CMD_SAMPLE, 1'b1, 32'h0000_0400);
    send_command(CMD_POP, 1'b0, 32'h0000_0000);
    send_command(CMD_POP, 1'b0, 32'h0000_0000);
    send_command(CMD_POP, 1'b0, 32'h0000_0000);
    pin_now = 1'b1;

    // random segments, each with its own register setting and pop rate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      send_idle = (seg < 3) ? 35 : (seg < 6) ? 71 : 0;
      recv_idle = (seg < 3) ? 71 : (seg < 6) ? 35 : 0;
      if (seg < 4) reg_write(REG_EDGE_MODE, seg % 4);
      else reg_write(REG_EDGE_MODE, $urandom_range(3));
      reg_write(REG_CAPTURE_ENABLE, DATA_W'((seg != 5) && ($urandom_range(7) != 0)));
      case ($urandom_range(3))
        0: pop_pct = 3;
        1: pop_pct = 15;
        2: pop_pct = 35;
        default: pop_pct = 55;
      endcase
      // both edges with hardly any pops fills the ring and forces overflow when capture is on
      if (seg == 2) pop_pct = 3;
      repeat (SEG_WORDS) send_random(pop_pct);
    end
    drain_results();

    if (ring_model.mismatch_count == 0 && ring_model.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
